### rtl/oosd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oosd_pkg
// Shared types and constants for the orientation offset and step detector:
// item operation codes, csr register indexes, field widths and reset values.
// ----------------------------------------------------------------------------

package oosd_pkg;

   // operation carried in req_tuser
   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_TICK      = 2'd1,
      OP_CALIBRATE = 2'd2
   } op_type;

   // csr port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_THRESHOLD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCKOUT_TICKS  = 1'b1;

   // register reset values
   localparam int STEP_THRESHOLD_RST = 154;
   localparam int LOCKOUT_TICKS_RST  = 500;

   // field widths
   localparam int OP_W        = 2;
   localparam int AZ_W        = 16;
   localparam int EL_W        = 15;
   localparam int ACCEL_W     = 16;
   localparam int THRESHOLD_W = 15;
   localparam int LOCKOUT_W   = 16;
   localparam int EL_OUT_W    = 16;

   // stream payload widths (padded to whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // default depths
   localparam int AVERAGE_DEPTH_DEF       = 100;
   localparam int CALIBRATION_SAMPLES_DEF = 100;

   // one full turn in centidegrees
   localparam int AZIMUTH_WRAP = 36000;

endpackage

`default_nettype wire

### rtl/orientation_offset_and_step_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orientation_offset_and_step_detector_core
// Head-tracker sample processing: moving-average step detection with a tick
// driven lockout, and azimuth/elevation offset calibration and correction.
// ----------------------------------------------------------------------------
//
// Every transfer on the req side gives exactly one transfer on the rsp side,
// in order. The block sustains one transfer per clock while the rsp side does
// not stall; a result passes stages 1 to 5 into the output register, is
// presented from there and transfers when rsp_tready is high. The
// acceleration history lives in a single-port ring memory of AVERAGE_DEPTH
// entries that is read and written at the same address in the request cycle
// (old data comes out through a register); a running sum stands for the average,
// so the step test never divides. A fill flag marks the ring as written once
// around, so entries never written read as zero and no clearing pass is
// needed after reset. Calibration offsets are the rounded accumulator sums
// divided by CALIBRATION_SAMPLES through a reciprocal multiply split into two
// pipeline stages; the offsets take effect for every sample behind the one
// that finishes calibration. Each stage holds its item only while the next
// one is full, so a waiting result does not block new requests until all six
// stages are occupied. csr writes are meant for an idle block.

module orientation_offset_and_step_detector_core #(
   parameter int AVERAGE_DEPTH       = oosd_pkg::AVERAGE_DEPTH_DEF,
   parameter int CALIBRATION_SAMPLES = oosd_pkg::CALIBRATION_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // azimuth_in[15:0], elevation_in[30:16], accel_z[46:31], zero pad
   input  wire logic [oosd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation[1:0]
   input  wire logic [oosd_pkg::OP_W-1:0]         req_tuser,
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // azimuth_out[15:0], elevation_out[31:16], step_detected[32],
   // calibration_done[33], calibrating[34], zero pad
   output logic [oosd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // orientation_valid[0]
   output logic                                   rsp_tuser,
   // csr write port
   input  wire logic                              csr_wen,
   input  wire logic [oosd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [oosd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------- sizes
   localparam int AZ_W     = oosd_pkg::AZ_W;
   localparam int EL_W     = oosd_pkg::EL_W;
   localparam int ACCEL_W  = oosd_pkg::ACCEL_W;
   localparam int LOCK_W   = oosd_pkg::LOCKOUT_W;
   localparam int ELO_W    = oosd_pkg::EL_OUT_W;

   // moving average
   localparam int AVG_L    = $clog2(AVERAGE_DEPTH);
   localparam int POS_W    = AVG_L;
   localparam int SUM_W    = ACCEL_W + AVG_L;
   localparam int TEST_W   = SUM_W + 2;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVERAGE_DEPTH - 1);

   // calibration
   localparam int CAL_L    = $clog2(CALIBRATION_SAMPLES);
   localparam int CNT_W    = $clog2(CALIBRATION_SAMPLES + 2);
   localparam int AZA_W    = AZ_W + CAL_L;
   localparam int ELA_W    = EL_W + CAL_L;
   localparam int DIV_W    = AZA_W + 1;
   localparam int REC_W    = DIV_W + 2;
   localparam int LO_W     = DIV_W / 2;
   localparam int HI_W     = DIV_W - LO_W;
   localparam int PL_W     = LO_W + REC_W;
   localparam int PH_W     = HI_W + REC_W;
   localparam int PROD_W   = DIV_W + REC_W;
   localparam int Q_W      = REC_W - CAL_L;
   localparam int HALF     = CALIBRATION_SAMPLES / 2;
   // floor(d * RECIP / 2^(DIV_W+CAL_L)) equals floor(d / N) for every d below 2^DIV_W
   localparam logic [REC_W-1:0] RECIP = REC_W'(((64'd1 << (DIV_W + CAL_L))
      + 64'(CALIBRATION_SAMPLES) - 64'd1) / 64'(CALIBRATION_SAMPLES));

   // ------------------------------------------------------------- handshake
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, rsp_v_ff;
   logic out_free, s5_free, s4_free, s3_free, s2_free, s1_free;
   logic s1_move, s2_move, s3_move, s4_move, s5_move;
   logic accept;
   oosd_pkg::op_type req_op;

   // a stage takes a new item when empty or when its own item moves on
   assign out_free = !rsp_v_ff || rsp_tready;
   assign s5_move  = s5_v_ff && out_free;
   assign s5_free  = !s5_v_ff || s5_move;
   assign s4_move  = s4_v_ff && s5_free;
   assign s4_free  = !s4_v_ff || s4_move;
   assign s3_move  = s3_v_ff && s4_free;
   assign s3_free  = !s3_v_ff || s3_move;
   assign s2_move  = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s2_move;
   assign s1_move  = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s1_move;

   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;
   assign req_op     = oosd_pkg::op_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_v_ff  <= accept;
         if (s2_free)  s2_v_ff  <= s1_v_ff;
         if (s3_free)  s3_v_ff  <= s2_v_ff;
         if (s4_free)  s4_v_ff  <= s3_v_ff;
         if (s5_free)  s5_v_ff  <= s4_v_ff;
         if (out_free) rsp_v_ff <= s5_v_ff;
      end
   end

   // ------------------------------------------------------------- csr regs
   logic signed [TEST_W-1:0] thr_scaled_ff;   // step_threshold times depth
   logic [LOCK_W-1:0]        lockout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_scaled_ff    <= TEST_W'(oosd_pkg::STEP_THRESHOLD_RST * AVERAGE_DEPTH);
         lockout_ticks_ff <= LOCK_W'(oosd_pkg::LOCKOUT_TICKS_RST);
      end else if (csr_wen) begin
         case (csr_addr)
            oosd_pkg::CSR_STEP_THRESHOLD: begin
               thr_scaled_ff <= $signed(TEST_W'(csr_wdata[oosd_pkg::THRESHOLD_W-1:0])
                                        * TEST_W'(AVERAGE_DEPTH));
            end
            oosd_pkg::CSR_LOCKOUT_TICKS: begin
               lockout_ticks_ff <= csr_wdata[LOCK_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------ ring memory (stage 1)
   logic signed [ACCEL_W-1:0] ring_mem [AVERAGE_DEPTH];
   logic signed [ACCEL_W-1:0] ring_rd_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      ring_full_ff;   // every entry written at least once
   logic                      req_sample;

   assign req_sample = accept && (req_op == oosd_pkg::OP_SAMPLE);

   // read-before-write at the same entry: old value out, new value in
   always_ff @(posedge clock) begin
      if (req_sample) begin
         ring_rd_ff       <= ring_mem[pos_ff];
         ring_mem[pos_ff] <= $signed(req_tdata[46:31]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ring_full_ff <= 1'b0;
      end else if (req_sample) begin
         if (pos_ff == POS_LAST) begin
            pos_ff       <= '0;
            ring_full_ff <= 1'b1;
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
         end
      end
   end

   // stage 1 payload
   oosd_pkg::op_type          s1_op_ff;
   logic [AZ_W-1:0]           s1_az_ff;
   logic signed [EL_W-1:0]    s1_el_ff;
   logic signed [ACCEL_W-1:0] s1_acc_ff;
   logic                      s1_full_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_op;
         s1_az_ff   <= req_tdata[15:0];
         s1_el_ff   <= $signed(req_tdata[30:16]);
         s1_acc_ff  <= $signed(req_tdata[46:31]);
         s1_full_ff <= ring_full_ff;
      end
   end

   // ------------------------------------------------ running sum (stage 2)
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ACCEL_W-1:0] old_acc;

   // an entry not yet written counts as zero; the ring itself is never reset
   assign old_acc = s1_full_ff ? ring_rd_ff : '0;
   assign sum_in  = sum_ff + SUM_W'(s1_acc_ff) - SUM_W'(old_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (s1_move && (s1_op_ff == oosd_pkg::OP_SAMPLE)) begin
         sum_ff <= sum_in;
      end
   end

   oosd_pkg::op_type         s2_op_ff;
   logic [AZ_W-1:0]          s2_az_ff;
   logic signed [EL_W-1:0]   s2_el_ff;
   logic                     s2_neg_ff;      // acceleration below zero
   logic signed [TEST_W-1:0] s2_scaled_ff;   // acceleration times depth
   logic signed [SUM_W-1:0]  s2_sum_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_op_ff     <= s1_op_ff;
         s2_az_ff     <= s1_az_ff;
         s2_el_ff     <= s1_el_ff;
         s2_neg_ff    <= s1_acc_ff[ACCEL_W-1];
         s2_scaled_ff <= TEST_W'(s1_acc_ff) * TEST_W'(AVERAGE_DEPTH);
         s2_sum_ff    <= sum_in;
      end
   end

   // ------------------------------- step test, lockout, calibration (stage 3)
   logic                     blocked_ff, blocked_in;
   logic [LOCK_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [AZA_W-1:0]         az_acc_ff, az_acc_in;
   logic signed [ELA_W-1:0]  el_acc_ff, el_acc_in;
   logic signed [TEST_W-1:0] sum_wide, sum_mag, excess;
   logic                     step_hit;
   logic                     s3_valid_in, s3_step_in, s3_done_in, s3_cal_in;
   logic [DIV_W-1:0]         daz_in, del_in, el_acc_ext;

   // exact test: accel*depth - |sum| > threshold*depth
   assign sum_wide = TEST_W'(s2_sum_ff);
   assign sum_mag  = sum_wide[TEST_W-1] ? -sum_wide : sum_wide;
   assign excess   = s2_scaled_ff - sum_mag;
   assign step_hit = !blocked_ff && !s2_neg_ff && (excess > thr_scaled_ff);

   // rounded dividends, halves away from zero: |x| + N/2
   assign el_acc_ext = DIV_W'(el_acc_ff);
   assign daz_in     = DIV_W'(az_acc_ff) + DIV_W'(HALF);
   assign del_in     = el_acc_ff[ELA_W-1] ? ~el_acc_ext + DIV_W'(HALF + 1)
                                          : el_acc_ext + DIV_W'(HALF);

   always_comb begin
      count_in    = count_ff;
      az_acc_in   = az_acc_ff;
      el_acc_in   = el_acc_ff;
      blocked_in  = blocked_ff;
      rem_in      = rem_ff;
      s3_valid_in = 1'b0;
      s3_step_in  = 1'b0;
      s3_done_in  = 1'b0;
      case (s2_op_ff)
         oosd_pkg::OP_SAMPLE: begin
            if (step_hit) begin
               s3_step_in = 1'b1;
               blocked_in = 1'b1;
               rem_in     = lockout_ticks_ff;
            end
            if (count_ff != '0) begin
               if (count_ff <= CNT_W'(CALIBRATION_SAMPLES)) begin
                  az_acc_in = az_acc_ff + AZA_W'(s2_az_ff);
                  el_acc_in = el_acc_ff + ELA_W'(s2_el_ff);
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  // sample after the last collected one sets the offsets
                  count_in   = '0;
                  s3_done_in = 1'b1;
               end
            end else begin
               s3_valid_in = 1'b1;
            end
         end
         oosd_pkg::OP_TICK: begin
            if (blocked_ff) begin
               // zero lockout acts as one tick
               if (rem_ff <= LOCK_W'(1)) begin
                  rem_in     = '0;
                  blocked_in = 1'b0;
               end else begin
                  rem_in = rem_ff - LOCK_W'(1);
               end
            end
         end
         oosd_pkg::OP_CALIBRATE: begin
            // restart collection, also while already collecting
            az_acc_in = '0;
            el_acc_in = '0;
            count_in  = CNT_W'(1);
         end
         default: ;
      endcase
      s3_cal_in = (count_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b0;
         rem_ff     <= '0;
         count_ff   <= '0;
         az_acc_ff  <= '0;
         el_acc_ff  <= '0;
      end else if (s2_move) begin
         blocked_ff <= blocked_in;
         rem_ff     <= rem_in;
         count_ff   <= count_in;
         az_acc_ff  <= az_acc_in;
         el_acc_ff  <= el_acc_in;
      end
   end

   logic                   s3_valid_ff, s3_step_ff, s3_done_ff, s3_cal_ff, s3_eneg_ff;
   logic [AZ_W-1:0]        s3_az_ff;
   logic signed [EL_W-1:0] s3_el_ff;
   logic [DIV_W-1:0]       s3_daz_ff, s3_del_ff;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_valid_ff <= s3_valid_in;
         s3_step_ff  <= s3_step_in;
         s3_done_ff  <= s3_done_in;
         s3_cal_ff   <= s3_cal_in;
         s3_az_ff    <= s2_az_ff;
         s3_el_ff    <= s2_el_ff;
         s3_daz_ff   <= daz_in;
         s3_del_ff   <= del_in;
         s3_eneg_ff  <= el_acc_ff[ELA_W-1];
      end
   end

   // ------------------------------------ reciprocal partial products (stage 4)
   logic                   s4_valid_ff, s4_step_ff, s4_done_ff, s4_cal_ff, s4_eneg_ff;
   logic [AZ_W-1:0]        s4_az_ff;
   logic signed [EL_W-1:0] s4_el_ff;
   logic [PL_W-1:0]        s4_az_lo_ff, s4_el_lo_ff;
   logic [PH_W-1:0]        s4_az_hi_ff, s4_el_hi_ff;

   always_ff @(posedge clock) begin
      if (s3_move) begin
         s4_valid_ff <= s3_valid_ff;
         s4_step_ff  <= s3_step_ff;
         s4_done_ff  <= s3_done_ff;
         s4_cal_ff   <= s3_cal_ff;
         s4_eneg_ff  <= s3_eneg_ff;
         s4_az_ff    <= s3_az_ff;
         s4_el_ff    <= s3_el_ff;
         s4_az_lo_ff <= PL_W'(s3_daz_ff[LO_W-1:0]) * PL_W'(RECIP);
         s4_az_hi_ff <= PH_W'(s3_daz_ff[DIV_W-1:LO_W]) * PH_W'(RECIP);
         s4_el_lo_ff <= PL_W'(s3_del_ff[LO_W-1:0]) * PL_W'(RECIP);
         s4_el_hi_ff <= PH_W'(s3_del_ff[DIV_W-1:LO_W]) * PH_W'(RECIP);
      end
   end

   // ------------------------------------------------ quotients (stage 5)
   logic [PROD_W-1:0] prod_az, prod_el;

   assign prod_az = (PROD_W'(s4_az_hi_ff) << LO_W) + PROD_W'(s4_az_lo_ff);
   assign prod_el = (PROD_W'(s4_el_hi_ff) << LO_W) + PROD_W'(s4_el_lo_ff);

   logic                   s5_valid_ff, s5_step_ff, s5_done_ff, s5_cal_ff, s5_eneg_ff;
   logic [AZ_W-1:0]        s5_az_ff;
   logic signed [EL_W-1:0] s5_el_ff;
   logic [Q_W-1:0]         s5_qaz_ff, s5_qel_ff;

   always_ff @(posedge clock) begin
      if (s4_move) begin
         s5_valid_ff <= s4_valid_ff;
         s5_step_ff  <= s4_step_ff;
         s5_done_ff  <= s4_done_ff;
         s5_cal_ff   <= s4_cal_ff;
         s5_eneg_ff  <= s4_eneg_ff;
         s5_az_ff    <= s4_az_ff;
         s5_el_ff    <= s4_el_ff;
         s5_qaz_ff   <= prod_az[PROD_W-1 -: Q_W];
         s5_qel_ff   <= prod_el[PROD_W-1 -: Q_W];
      end
   end

   // ------------------------------------ offsets and correction (output)
   logic [AZ_W-1:0]         az_off_ff;
   logic signed [EL_W-1:0]  el_off_ff;
   logic signed [EL_W-1:0]  el_q;
   logic [AZ_W:0]           az_diff, az_corr;
   logic signed [ELO_W-1:0] el_diff;
   logic [AZ_W-1:0]         az_out;
   logic [ELO_W-1:0]        el_out;

   assign el_q = $signed(s5_qel_ff[EL_W-1:0]);

   // offsets change in order, so later samples see them and earlier ones do not
   always_ff @(posedge clock) begin
      if (reset) begin
         az_off_ff <= '0;
         el_off_ff <= '0;
      end else if (s5_move && s5_done_ff) begin
         az_off_ff <= s5_qaz_ff[AZ_W-1:0];
         el_off_ff <= s5_eneg_ff ? -el_q : el_q;
      end
   end

   always_comb begin
      az_diff = {1'b0, s5_az_ff} - {1'b0, az_off_ff};
      // a negative difference gets one turn added, then keeps its low bits
      az_corr = az_diff[AZ_W] ? az_diff + (AZ_W + 1)'(oosd_pkg::AZIMUTH_WRAP) : az_diff;
      el_diff = ELO_W'(s5_el_ff) - ELO_W'(el_off_ff);
      if (s5_valid_ff) begin
         az_out = az_corr[AZ_W-1:0];
         el_out = el_diff;
      end else begin
         az_out = '0;
         el_out = '0;
      end
   end

   logic [oosd_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_user_ff;

   always_ff @(posedge clock) begin
      if (s5_move) begin
         rsp_data_ff <= {5'b0, s5_cal_ff, s5_done_ff, s5_step_ff, el_out, az_out};
         rsp_user_ff <= s5_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------- checks
   // lockout count only runs while steps are blocked
   a_lockout_idle: assert property (@(posedge clock) disable iff (reset)
      !blocked_ff |-> (rem_ff == '0))
      else $error("lockout count left while steps are unblocked");

   // calibration count never passes the finishing sample
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CALIBRATION_SAMPLES + 1))
      else $error("calibration count out of range");

   // requests are held off only when the response side is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without response stall");

   // a transfer that finishes calibration never carries a corrected sample
   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      s5_move |=> !(rsp_tuser && rsp_tdata[33]))
      else $error("calibration done with orientation valid");

endmodule

`default_nettype wire
